FILE: src/hrpc_pkg.sv
// Package for the HSV red pixel classifier.
// Holds widths, the threshold box table, pipeline payload types and latency.
// No dependencies.
package hrpc_pkg;

  localparam int CH_W      = 8;
  localparam int DEN_W     = 9;
  localparam int SQ_W      = 8;
  localparam int HQ_W      = 9;
  localparam int S_NUM_W   = 17;
  localparam int H_NUM_W   = 18;
  localparam int HH_W      = 12;
  localparam int E_W       = 9;
  localparam int NUM_BOXES = 9;
  localparam int HIT_W     = 8;
  localparam int HUE_MOD   = 180;
  localparam int DIV_STEPS = HQ_W;
  localparam int LATENCY   = 4 + DIV_STEPS + 2;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [CH_W-1:0] hlo;
    logic [CH_W-1:0] slo;
    logic [CH_W-1:0] vlo;
    logic [CH_W-1:0] hhi;
    logic [CH_W-1:0] shi;
    logic [CH_W-1:0] vhi;
  } box_t;

  localparam box_t BOXES [NUM_BOXES] = '{
    '{8'd0,   8'd25, 8'd98, 8'd11,  8'd39,  8'd144},
    '{8'd156, 8'd30, 8'd79, 8'd179, 8'd93,  8'd151},
    '{8'd0,   8'd25, 8'd60, 8'd35,  8'd40,  8'd75},
    '{8'd169, 8'd28, 8'd78, 8'd173, 8'd90,  8'd152},
    '{8'd157, 8'd28, 8'd58, 8'd177, 8'd78,  8'd81},
    '{8'd142, 8'd67, 8'd44, 8'd165, 8'd102, 8'd104},
    '{8'd0,   8'd50, 8'd50, 8'd10,  8'd255, 8'd255},
    '{8'd160, 8'd50, 8'd50, 8'd180, 8'd255, 8'd255},
    '{8'd110, 8'd30, 8'd75, 8'd160, 8'd75,  8'd120}
  };

  // State of the two restoring dividers, one quotient bit per stage.
  typedef struct packed {
    logic [DEN_W-1:0] rem_s;
    logic [SQ_W-1:0]  low_s;
    logic [SQ_W-1:0]  q_s;
    logic [DEN_W-1:0] den_s;
    logic [DEN_W-1:0] rem_h;
    logic [HQ_W-1:0]  low_h;
    logic [HQ_W-1:0]  q_h;
    logic [DEN_W-1:0] den_h;
    logic [CH_W-1:0]  v;
    logic             grey;
  } div_t;

endpackage

FILE: src/hrpc_front.sv
// Front end of the classifier: max/min search, hue offset and divider setup.
// Four register stages. Depends on hrpc_pkg.
module hrpc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    red_i,
  output logic          valid_o,
  output hrpc_pkg::div_t div_o
);
  import hrpc_pkg::*;

  logic [3:0] valid_r;

  logic [CH_W-1:0] b1_r, g1_r, r1_r, mx1_r, mn1_r;
  logic [CH_W-1:0] mx1_nxt, mn1_nxt;
  max_sel_t        sel1_r, sel1_nxt;

  logic [CH_W-1:0] d2_r, mx2_r, d2_nxt;
  logic [E_W-1:0]  e2_r, e2_nxt;
  max_sel_t        sel2_r;

  logic [HH_W-1:0]    hh3_r, hh3_nxt;
  logic [HH_W-1:0]    base3;
  logic [HH_W:0]      hh3_full;
  logic [CH_W-1:0]    d3_r, mx3_r;
  logic [S_NUM_W-1:0] ns3_r, ns3_nxt;

  logic [H_NUM_W-1:0] nh4;
  div_t               div4_r, div4_nxt;

  always_comb begin
    mx1_nxt = red_i;
    if (green_i > mx1_nxt) mx1_nxt = green_i;
    if (blue_i > mx1_nxt) mx1_nxt = blue_i;
    mn1_nxt = red_i;
    if (green_i < mn1_nxt) mn1_nxt = green_i;
    if (blue_i < mn1_nxt) mn1_nxt = blue_i;
    if (mx1_nxt == red_i) begin
      sel1_nxt = MAX_RED;
    end else if (mx1_nxt == green_i) begin
      sel1_nxt = MAX_GREEN;
    end else begin
      sel1_nxt = MAX_BLUE;
    end
  end

  always_comb begin
    d2_nxt = mx1_r - mn1_r;
    case (sel1_r)
      MAX_RED:   e2_nxt = {1'b0, g1_r} - {1'b0, b1_r};
      MAX_GREEN: e2_nxt = {1'b0, b1_r} - {1'b0, r1_r};
      MAX_BLUE:  e2_nxt = {1'b0, r1_r} - {1'b0, g1_r};
      default:   e2_nxt = '0;
    endcase
  end

  always_comb begin
    case (sel2_r)
      MAX_RED:   base3 = HH_W'(d2_r) * HH_W'(6);
      MAX_GREEN: base3 = HH_W'(d2_r) * HH_W'(8);
      MAX_BLUE:  base3 = HH_W'(d2_r) * HH_W'(10);
      default:   base3 = '0;
    endcase
    hh3_full = {1'b0, base3} + {{(HH_W + 1 - E_W){e2_r[E_W-1]}}, e2_r};
    hh3_nxt  = hh3_full[HH_W-1:0];
    ns3_nxt  = S_NUM_W'(d2_r) * S_NUM_W'(510) + S_NUM_W'(mx2_r);
  end

  always_comb begin
    nh4            = H_NUM_W'(hh3_r) * H_NUM_W'(60) + H_NUM_W'(d3_r);
    div4_nxt.rem_s = ns3_r[S_NUM_W-1:SQ_W];
    div4_nxt.low_s = ns3_r[SQ_W-1:0];
    div4_nxt.q_s   = '0;
    div4_nxt.den_s = {mx3_r, 1'b0};
    div4_nxt.rem_h = nh4[H_NUM_W-1:HQ_W];
    div4_nxt.low_h = nh4[HQ_W-1:0];
    div4_nxt.q_h   = '0;
    div4_nxt.den_h = {d3_r, 1'b0};
    div4_nxt.v     = mx3_r;
    div4_nxt.grey  = (d3_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    b1_r   <= blue_i;
    g1_r   <= green_i;
    r1_r   <= red_i;
    mx1_r  <= mx1_nxt;
    mn1_r  <= mn1_nxt;
    sel1_r <= sel1_nxt;
    d2_r   <= d2_nxt;
    e2_r   <= e2_nxt;
    mx2_r  <= mx1_r;
    sel2_r <= sel1_r;
    hh3_r  <= hh3_nxt;
    d3_r   <= d2_r;
    mx3_r  <= mx2_r;
    ns3_r  <= ns3_nxt;
    div4_r <= div4_nxt;
  end

  assign valid_o = valid_r[3];
  assign div_o   = div4_r;

endmodule

FILE: src/hrpc_div_step.sv
// One restoring division step for the saturation and hue dividers.
// One hue quotient bit per stage; one saturation bit if STEP_S. Depends on hrpc_pkg.
module hrpc_div_step #(
  parameter bit STEP_S = 1'b1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  hrpc_pkg::div_t div_i,
  output logic           valid_o,
  output hrpc_pkg::div_t div_o
);
  import hrpc_pkg::*;

  logic             valid_r;
  div_t             div_r, div_nxt;
  logic [DEN_W:0]   cat_s, sub_s, cat_h, sub_h;
  logic             ge_s, ge_h;

  always_comb begin
    div_nxt = div_i;
    cat_s   = {div_i.rem_s, div_i.low_s[SQ_W-1]};
    sub_s   = cat_s - {1'b0, div_i.den_s};
    ge_s    = (cat_s >= {1'b0, div_i.den_s});
    cat_h   = {div_i.rem_h, div_i.low_h[HQ_W-1]};
    sub_h   = cat_h - {1'b0, div_i.den_h};
    ge_h    = (cat_h >= {1'b0, div_i.den_h});
    if (STEP_S) begin
      div_nxt.rem_s = ge_s ? sub_s[DEN_W-1:0] : cat_s[DEN_W-1:0];
      div_nxt.q_s   = {div_i.q_s[SQ_W-2:0], ge_s};
      div_nxt.low_s = {div_i.low_s[SQ_W-2:0], 1'b0};
    end
    div_nxt.rem_h = ge_h ? sub_h[DEN_W-1:0] : cat_h[DEN_W-1:0];
    div_nxt.q_h   = {div_i.q_h[HQ_W-2:0], ge_h};
    div_nxt.low_h = {div_i.low_h[HQ_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign valid_o = valid_r;
  assign div_o   = div_r;

endmodule

FILE: src/hrpc_classify.sv
// Back end of the classifier: hue wrap, zero cases and threshold box tests.
// Two register stages, the second is the output register. Depends on hrpc_pkg.
module hrpc_classify (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  hrpc_pkg::div_t div_i,
  output logic           valid_o,
  output logic           is_red_o,
  output logic [7:0]     box_hits_o,
  output logic [7:0]     hue_value_o
);
  import hrpc_pkg::*;

  logic [1:0]      valid_r;
  logic [HQ_W-1:0] t_wrap;
  logic [CH_W-1:0] h_r, s_r, v_r, h_nxt, s_nxt;
  logic [NUM_BOXES-1:0] hit;
  logic            is_red_r;
  logic [HIT_W-1:0] hits_r;
  logic [CH_W-1:0] hue_r;

  always_comb begin
    t_wrap = (div_i.q_h >= HQ_W'(HUE_MOD)) ? div_i.q_h - HQ_W'(HUE_MOD) : div_i.q_h;
    h_nxt  = div_i.grey ? '0 : t_wrap[CH_W-1:0];
    s_nxt  = (div_i.v == '0) ? '0 : div_i.q_s;
  end

  always_comb begin
    for (int k = 0; k < NUM_BOXES; k++) begin
      hit[k] = (h_r >= BOXES[k].hlo) && (h_r <= BOXES[k].hhi) &&
               (s_r >= BOXES[k].slo) && (s_r <= BOXES[k].shi) &&
               (v_r >= BOXES[k].vlo) && (v_r <= BOXES[k].vhi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    h_r      <= h_nxt;
    s_r      <= s_nxt;
    v_r      <= div_i.v;
    is_red_r <= |hit;
    hits_r   <= hit[HIT_W-1:0];
    hue_r    <= h_r;
  end

  assign valid_o     = valid_r[1];
  assign is_red_o    = is_red_r;
  assign box_hits_o  = hits_r;
  assign hue_value_o = hue_r;

endmodule

FILE: src/hsv_red_pixel_classifier.sv
// A pixel passes front end, divider steps and classify stages to out_valid.
// Throughput: one pixel per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the two restoring dividers, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears all stage valid bits; pixels accepted
// before reset are dropped and their results are never strobed.
module hsv_red_pixel_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  output logic       out_valid,
  output logic       out_is_red,
  output logic [7:0] out_box_hits,
  output logic [7:0] out_hue_value
);
  import hrpc_pkg::*;

  logic valid_q [DIV_STEPS+1];
  div_t div_q   [DIV_STEPS+1];

  assign busy = 1'b0;

  hrpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start & ~busy),
    .blue_i  (in_blue),
    .green_i (in_green),
    .red_i   (in_red),
    .valid_o (valid_q[0]),
    .div_o   (div_q[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hrpc_div_step #(
      .STEP_S (i < SQ_W)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_q[i]),
      .div_i   (div_q[i]),
      .valid_o (valid_q[i+1]),
      .div_o   (div_q[i+1])
    );
  end

  hrpc_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (valid_q[DIV_STEPS]),
    .div_i       (div_q[DIV_STEPS]),
    .valid_o     (out_valid),
    .is_red_o    (out_is_red),
    .box_hits_o  (out_box_hits),
    .hue_value_o (out_hue_value)
  );

endmodule

FILE: src/hrpc_checker.sv
// Port-level checker for the HSV red pixel classifier, bound to the top level.
// Depends on hrpc_pkg for the pipeline latency.
module hrpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_blue,
  input logic [7:0] in_green,
  input logic [7:0] in_red,
  input logic       out_valid,
  input logic       out_is_red,
  input logic [7:0] out_box_hits,
  input logic [7:0] out_hue_value
);
  import hrpc_pkg::*;

  a_lat_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result at the expected cycle");

  a_lat_back : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  a_hits_red : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_box_hits != 8'd0) |-> out_is_red)
    else $error("box hit reported without the red flag");

  a_grey_hue : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_blue == in_green && in_green == in_red)
      |-> ##LATENCY (out_hue_value == 8'd0 && out_hue_value < 8'd180))
    else $error("grey pixel gave a nonzero hue");

endmodule

bind hsv_red_pixel_classifier hrpc_checker u_hrpc_checker (.*);

FILE: dv/tb_hsv_red_pixel_classifier.sv
// Self-checking testbench for the HSV red pixel classifier.
// Drives directed and random BGR pixels and checks every result against a typed result or a
// local HSV conversion and threshold window predictor. Depends on src/hrpc_pkg.sv.
module tb_hsv_red_pixel_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WINDOWS = 9;
  localparam int RANDOM_PER_PHASE = 645;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic       is_red;
    logic [7:0] box_hits;
    logic [7:0] hue_value;
  } pixel_class_t;

  typedef struct {
    logic [7:0]   blue;
    logic [7:0]   green;
    logic [7:0]   red;
    bit           typed;
    pixel_class_t result;
  } pixel_row_t;

  // Each window is hue low, sat low, value low, hue high, sat high, value high.
  int unsigned red_windows [NUM_WINDOWS][6] = '{
    '{0,   25, 98, 11,  39,  144},
    '{156, 30, 79, 179, 93,  151},
    '{0,   25, 60, 35,  40,  75},
    '{169, 28, 78, 173, 90,  152},
    '{157, 28, 58, 177, 78,  81},
    '{142, 67, 44, 165, 102, 104},
    '{0,   50, 50, 10,  255, 255},
    '{160, 50, 50, 180, 255, 255},
    '{110, 30, 75, 160, 75,  120}
  };

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic       out_valid;
  logic       out_is_red;
  logic [7:0] out_box_hits;
  logic [7:0] out_hue_value;

  pixel_class_t expected_classes [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  hsv_red_pixel_classifier i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_is_red    (out_is_red),
    .out_box_hits  (out_box_hits),
    .out_hue_value (out_hue_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic pixel_class_t classify_pixel(input logic [7:0] b, input logic [7:0] g,
                                                  input logic [7:0] r);
    int unsigned        mx;
    int unsigned        mn;
    int unsigned        diff;
    int unsigned        sat;
    int unsigned        hh;
    int unsigned        hue;
    hrpc_pkg::max_sel_t sel;
    pixel_class_t       res;
    mx = 32'(r);
    sel = hrpc_pkg::MAX_RED;
    if (g > mx) begin
      mx = 32'(g);
      sel = hrpc_pkg::MAX_GREEN;
    end
    if (b > mx) begin
      mx = 32'(b);
      sel = hrpc_pkg::MAX_BLUE;
    end
    mn = 32'(r);
    if (g < mn) mn = 32'(g);
    if (b < mn) mn = 32'(b);
    diff = mx - mn;
    sat = (mx == 0) ? 0 : (510 * diff + mx) / (2 * mx);
    if (diff == 0) begin
      hue = 0;
    end else begin
      case (sel)
        hrpc_pkg::MAX_RED:   hh = 6 * diff + 32'(g) - 32'(b);
        hrpc_pkg::MAX_GREEN: hh = 8 * diff + 32'(b) - 32'(r);
        default:             hh = 10 * diff + 32'(r) - 32'(g);
      endcase
      hue = (60 * hh + diff) / (2 * diff);
      if (hue >= 180) hue -= 180;
      if (hue >= 180) hue -= 180;
    end
    res.is_red = 1'b0;
    res.box_hits = '0;
    res.hue_value = hue[7:0];
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      if (hue >= red_windows[k][0] && hue <= red_windows[k][3] &&
          sat >= red_windows[k][1] && sat <= red_windows[k][4] &&
          mx >= red_windows[k][2] && mx <= red_windows[k][5]) begin
        res.is_red = 1'b1;
        if (k < 8) res.box_hits[k] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit typed, input pixel_class_t typed_res, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (busy !== 1'b0);
    expected_classes.insert(expected_classes.size(),
                            typed ? typed_res : classify_pixel(b, g, r));
    @(negedge clk);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    while (expected_classes.size() != 0) @(negedge clk);
  endtask

  task automatic make_pixel(output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
    int unsigned pick;
    int unsigned top;
    int unsigned low;
    int unsigned mid;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      b = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      r = 8'($urandom_range(0, 255));
    end else if (pick < 85) begin
      top = $urandom_range(40, 255);
      low = top - (top * $urandom_range(5, 70)) / 100;
      mid = $urandom_range(low, low + (top - low) / 2);
      if ($urandom_range(0, 9) < 7) begin
        r = 8'(top);
        if ($urandom_range(0, 1)) begin
          g = 8'(low);
          b = 8'(mid);
        end else begin
          g = 8'(mid);
          b = 8'(low);
        end
      end else begin
        b = 8'(top);
        r = 8'($urandom_range(mid, top));
        g = 8'(low);
      end
    end else begin
      top = $urandom_range(0, 255);
      low = $urandom_range(0, top);
      case ($urandom_range(0, 3))
        0: begin b = 8'(top); g = 8'(top); r = 8'(top); end
        1: begin b = 8'(low); g = 8'(top); r = 8'(top); end
        2: begin b = 8'(top); g = 8'(top); r = 8'(low); end
        default: begin b = 8'(top); g = 8'(low); r = 8'(top); end
      endcase
    end
  endtask

  always @(posedge clk) begin
    pixel_class_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_red_pixel_classifier verification failed");
      $finish;
    end
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_classes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected transaction: is_red=%0b box_hits=%02h hue=%0d",
                   out_is_red, out_box_hits, out_hue_value);
      end else begin
        exp_res = expected_classes.pop_front();
        if (out_is_red !== exp_res.is_red || out_box_hits !== exp_res.box_hits ||
            out_hue_value !== exp_res.hue_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch: expected is_red=%0b box_hits=%02h hue=%0d, got %0b %02h %0d",
                     exp_res.is_red, exp_res.box_hits, exp_res.hue_value,
                     out_is_red, out_box_hits, out_hue_value);
        end
      end
    end
  end

  initial begin
    pixel_row_t   directed_rows [$];
    pixel_class_t no_class;
    int           phase_idle [3];
    logic [7:0]   b;
    logic [7:0]   g;
    logic [7:0]   r;
    no_class = '{1'b0, 8'h00, 8'h00};
    phase_idle = '{18, 59, 0};
    directed_rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 8'h00, 8'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{1'b0, 8'h00, 8'd0}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{1'b1, 8'h40, 8'd0}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{1'b0, 8'h00, 8'd60}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{1'b0, 8'h00, 8'd120}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{1'b0, 8'h00, 8'd0}},
      '{8'd0,   8'd255, 8'd255, 1'b0, no_class},
      '{8'd255, 8'd255, 8'd0,   1'b0, no_class},
      '{8'd255, 8'd0,   8'd255, 1'b0, no_class},
      '{8'd40,  8'd20,  8'd100, 1'b0, no_class},
      '{8'd100, 8'd80,  8'd93,  1'b0, no_class},
      '{8'hAA,  8'h55,  8'hFF,  1'b0, no_class},
      '{8'h55,  8'hAA,  8'h01,  1'b0, no_class},
      '{8'd105, 8'd106, 8'd120, 1'b0, no_class},
      '{8'd110, 8'd105, 8'd130, 1'b0, no_class},
      '{8'd61,  8'd65,  8'd70,  1'b0, no_class},
      '{8'd65,  8'd55,  8'd75,  1'b0, no_class},
      '{8'd100, 8'd70,  8'd98,  1'b0, no_class},
      '{8'd30,  8'd20,  8'd200, 1'b0, no_class},
      '{8'd254, 8'd0,   8'd255, 1'b0, no_class},
      '{8'd1,   8'd0,   8'd255, 1'b0, no_class},
      '{8'd0,   8'd1,   8'd1,   1'b0, no_class},
      '{8'd254, 8'd255, 8'd253, 1'b0, no_class}
    };
    rst_n = 1'b0;
    start = 1'b0;
    in_blue = '0;
    in_green = '0;
    in_red = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                 directed_rows[i].typed, directed_rows[i].result, 0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        make_pixel(b, g, r);
        send_pixel(b, g, r, 1'b0, no_class, phase_idle[phase]);
      end
      drain_results();
    end

    repeat (hrpc_pkg::LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_classes.size() == 0) begin
      $display("hsv_red_pixel_classifier verification clean");
    end else begin
      $display("hsv_red_pixel_classifier verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hrpc_pkg.sv
src/hrpc_front.sv
src/hrpc_div_step.sv
src/hrpc_classify.sv
src/hsv_red_pixel_classifier.sv
src/hrpc_checker.sv
dv/tb_hsv_red_pixel_classifier.sv
